// ----- sv/cpt_pkg.sv -----
// ============================================================================
// cpt_pkg - shared types and constants for the cascadable prescaled timers
// Request/response payloads, operation codes, control word bit positions and
// the controller/datapath command and status groups.
// ============================================================================
package cpt_pkg;

    // Operation codes carried in the request
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_WR_RELOAD  = 3'd1;
    localparam logic [2:0] OP_WR_CONTROL = 3'd2;
    localparam logic [2:0] OP_RD_COUNT   = 3'd3;
    localparam logic [2:0] OP_RD_CONTROL = 3'd4;

    // Control word bit positions
    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_EN_BIT  = 6;
    localparam int CTL_ENABLE_BIT  = 7;

    // Prescaler select codes (control bits 1:0)
    localparam logic [1:0] PSC_DIV1    = 2'd0;
    localparam logic [1:0] PSC_DIV64   = 2'd1;
    localparam logic [1:0] PSC_DIV256  = 2'd2;
    localparam logic [1:0] PSC_DIV1024 = 2'd3;

    localparam int COUNT_W = 16;
    localparam int REM_W   = 10;
    localparam int IRQ_W   = 4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  timer_index;
        logic [15:0] write_value;
        logic [7:0]  elapsed_cycles;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  timer_irq;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the request
        logic exec;        // run a register access or open a tick
        logic setup;       // split cycles of the current timer into ticks
        logic step;        // one tick of the current timer plus its chain
        logic next_timer;  // advance to the following timer
        logic publish;     // load the response register
    } cpt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_tick;
        logic ticks_done;
        logic timer_last;
    } cpt_status_t;

endpackage

// ----- sv/cascadable_prescaled_timers_unit.sv -----
// Sequence: a register access runs execute, then done loads the response register;
// a tick runs execute, then per timer a setup and a step per tick, where ticks_t is
// (remainder + elapsed_cycles) / prescale period, with one tick and its full cascade
// chain per clock. One item is in work at a time; the next request transfer can follow
// in the cycle after the response loads; an unaccepted earlier response holds that load.
// Reset (rst_n, async, active low) clears all timer state and drops any pending response.
// ============================================================================
// cascadable_prescaled_timers_unit - four cascadable 16-bit prescaled timers
// Top level: joins the sequencer and the timer datapath. Requests are tick
// items or register accesses; every request yields exactly one response.
// ============================================================================
module cascadable_prescaled_timers_unit
#(
    parameter int NUM_TIMERS = 4,
    parameter int MAX_CYCLES = 255
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cpt_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cpt_pkg::rsp_t  rsp_data
);

    // command and status groups between the sequencer and the datapath
    cpt_pkg::cpt_cmd_t    cmd;
    cpt_pkg::cpt_status_t status;

    // sequencer: accepts a request transfer only when idle, steps the work,
    // and holds the finished result until the response register is free
    cpt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: timer state, prescale split, cascade chain, response register
    cpt_datapath
    #(
        .NUM_TIMERS (NUM_TIMERS),
        .MAX_CYCLES (MAX_CYCLES)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .rsp_data (rsp_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ----- sv/cpt_ctrl.sv -----
// ============================================================================
// cpt_ctrl - sequencer for the timer block
// Walks each item through execute and, for a tick, per-timer setup and tick
// stepping, and owns the request/response handshake.
// ============================================================================
module cpt_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  cpt_pkg::cpt_status_t   status,
    output cpt_pkg::cpt_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.is_tick ? S_SETUP : S_DONE;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (!status.ticks_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (status.timer_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_timer = 1'b1;
                    state_next     = S_SETUP;
                end
            end
            S_DONE:
            begin
                // hold until the response register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- sv/cpt_datapath.sv -----
// ============================================================================
// cpt_datapath - timer registers, prescale split and cascade chain
// Holds counters, reloads, control words and remainders, the latched request,
// the per-timer tick counter, the interrupt collector and the response.
// ============================================================================
module cpt_datapath
#(
    parameter int NUM_TIMERS = 4,
    parameter int MAX_CYCLES = 255
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cpt_pkg::req_t          req_data,
    output cpt_pkg::rsp_t          rsp_data,
    input  cpt_pkg::cpt_cmd_t      cmd,
    output cpt_pkg::cpt_status_t   status
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ACC_W = $clog2((1 << cpt_pkg::REM_W) - 1 + MAX_CYCLES + 1);
    localparam int CW    = cpt_pkg::COUNT_W;
    localparam int RW    = cpt_pkg::REM_W;

    logic [CW-1:0]    count_reg   [NUM_TIMERS];
    logic [CW-1:0]    count_next  [NUM_TIMERS];
    logic [CW-1:0]    reload_reg  [NUM_TIMERS];
    logic [CW-1:0]    reload_next [NUM_TIMERS];
    logic [CW-1:0]    control_reg [NUM_TIMERS];
    logic [CW-1:0]    control_next[NUM_TIMERS];
    logic [RW-1:0]    rem_reg     [NUM_TIMERS];
    logic [RW-1:0]    rem_next    [NUM_TIMERS];

    logic [2:0]       op_reg;
    logic [1:0]       index_reg;
    logic [CW-1:0]    value_reg;
    logic [ACC_W-1:0] cycles_reg;
    logic [ACC_W-1:0] cycles_sat;

    logic [IDX_W-1:0] timer_reg;
    logic [IDX_W-1:0] timer_next;
    logic [ACC_W-1:0] ticks_reg;
    logic [ACC_W-1:0] ticks_next;
    logic [NUM_TIMERS-1:0] irq_reg;
    logic [NUM_TIMERS-1:0] irq_next;
    logic [CW-1:0]    rdata_reg;
    logic [CW-1:0]    rdata_next;
    cpt_pkg::rsp_t    rsp_reg;

    logic             index_ok;
    logic [IDX_W-1:0] addr;
    logic [CW-1:0]    sel_count;
    logic [CW-1:0]    sel_reload;
    logic [CW-1:0]    sel_control;
    logic [RW-1:0]    sel_rem;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] split_ticks;
    logic [RW-1:0]    split_rem;
    logic [NUM_TIMERS-1:0] stepped;
    logic [NUM_TIMERS-1:0] wraps;
    logic             carry;

    // saturate the cycle count at the configured ceiling
    always_comb
    begin
        if (ACC_W'(req_data.elapsed_cycles) > ACC_W'(MAX_CYCLES))
        begin
            cycles_sat = ACC_W'(MAX_CYCLES);
        end
        else
        begin
            cycles_sat = ACC_W'(req_data.elapsed_cycles);
        end
    end

    assign index_ok = (int'(index_reg) < NUM_TIMERS);
    assign addr     = (op_reg == cpt_pkg::OP_TICK) ? timer_reg : IDX_W'(index_reg);

    assign sel_count   = count_reg[addr];
    assign sel_reload  = reload_reg[addr];
    assign sel_control = control_reg[addr];
    assign sel_rem     = rem_reg[addr];

    // split accumulated cycles into whole prescaler periods and a remainder
    assign acc = ACC_W'(sel_rem) + cycles_reg;

    always_comb
    begin
        case (sel_control[1:0])
            cpt_pkg::PSC_DIV1:
            begin
                split_ticks = acc;
                split_rem   = '0;
            end
            cpt_pkg::PSC_DIV64:
            begin
                split_ticks = acc >> 6;
                split_rem   = RW'(acc[5:0]);
            end
            cpt_pkg::PSC_DIV256:
            begin
                split_ticks = acc >> 8;
                split_rem   = RW'(acc[7:0]);
            end
            default:
            begin
                split_ticks = acc >> 10;
                split_rem   = acc[9:0];
            end
        endcase
    end

    // cascade chain: the current timer steps, each overflow steps the next
    // enabled cascade timer, and the chain stops at the first non-overflow
    always_comb
    begin
        carry = 1'b0;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            wraps[j] = (count_reg[j] == {CW{1'b1}});
            if (IDX_W'(j) == timer_reg)
            begin
                stepped[j] = 1'b1;
            end
            else
            begin
                stepped[j] = carry & control_reg[j][cpt_pkg::CTL_ENABLE_BIT]
                                   & control_reg[j][cpt_pkg::CTL_CASCADE_BIT];
            end
            carry = stepped[j] & wraps[j];
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            count_next[j]   = count_reg[j];
            reload_next[j]  = reload_reg[j];
            control_next[j] = control_reg[j];
            rem_next[j]     = rem_reg[j];
        end
        timer_next = timer_reg;
        ticks_next = ticks_reg;
        irq_next   = irq_reg;
        rdata_next = rdata_reg;

        if (cmd.exec)
        begin
            timer_next = '0;
            irq_next   = '0;
            rdata_next = '0;
            unique case (op_reg)
                cpt_pkg::OP_TICK:
                begin
                end
                cpt_pkg::OP_WR_RELOAD:
                begin
                    if (index_ok)
                    begin
                        reload_next[addr] = value_reg;
                    end
                end
                cpt_pkg::OP_WR_CONTROL:
                begin
                    if (index_ok)
                    begin
                        control_next[addr] = value_reg;
                        // enable rising edge loads the counter
                        if (!sel_control[cpt_pkg::CTL_ENABLE_BIT]
                            && value_reg[cpt_pkg::CTL_ENABLE_BIT])
                        begin
                            count_next[addr] = sel_reload;
                        end
                    end
                end
                cpt_pkg::OP_RD_COUNT:
                begin
                    if (index_ok)
                    begin
                        rdata_next = sel_count;
                    end
                end
                cpt_pkg::OP_RD_CONTROL:
                begin
                    if (index_ok)
                    begin
                        rdata_next = sel_control;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.setup)
        begin
            if (sel_control[cpt_pkg::CTL_ENABLE_BIT]
                && !sel_control[cpt_pkg::CTL_CASCADE_BIT])
            begin
                ticks_next    = split_ticks;
                rem_next[addr] = split_rem;
            end
            else
            begin
                ticks_next = '0;
            end
        end

        if (cmd.step)
        begin
            ticks_next = ticks_reg - ACC_W'(1);
            for (int j = 0; j < NUM_TIMERS; j++)
            begin
                if (stepped[j])
                begin
                    if (wraps[j])
                    begin
                        count_next[j] = reload_reg[j];
                        if (control_reg[j][cpt_pkg::CTL_IRQ_EN_BIT])
                        begin
                            irq_next[j] = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next[j] = count_reg[j] + CW'(1);
                    end
                end
            end
        end

        if (cmd.next_timer)
        begin
            timer_next = timer_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_TIMERS; j++)
            begin
                count_reg[j]   <= '0;
                reload_reg[j]  <= '0;
                control_reg[j] <= '0;
                rem_reg[j]     <= '0;
            end
            op_reg    <= cpt_pkg::OP_TICK;
            timer_reg <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < NUM_TIMERS; j++)
            begin
                count_reg[j]   <= count_next[j];
                reload_reg[j]  <= reload_next[j];
                control_reg[j] <= control_next[j];
                rem_reg[j]     <= rem_next[j];
            end
            if (cmd.accept)
            begin
                op_reg <= req_data.operation;
            end
            timer_reg <= timer_next;
            ticks_reg <= ticks_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            index_reg  <= req_data.timer_index;
            value_reg  <= req_data.write_value;
            cycles_reg <= cycles_sat;
        end
        irq_reg   <= irq_next;
        rdata_reg <= rdata_next;
        if (cmd.publish)
        begin
            rsp_reg.read_data <= rdata_reg;
            rsp_reg.timer_irq <= cpt_pkg::IRQ_W'(irq_reg);
        end
    end

    assign rsp_data          = rsp_reg;
    assign status.is_tick    = (op_reg == cpt_pkg::OP_TICK);
    assign status.ticks_done = (ticks_reg == '0);
    assign status.timer_last = (timer_reg == IDX_W'(NUM_TIMERS - 1));

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for the cascadable prescaled timers unit
// Drives register accesses and tick transfers through the request channel,
// predicts every response with a cycle-free model of the four timers, and
// compares each response transfer field by field in order of arrival.
// ============================================================================
module tb;

    localparam int TIMERS     = 4;
    localparam int CYCLE_CAP  = 255;
    localparam int IDLE_LIMIT = 30000;   // cycles without any transfer

    // Codes the block has no meaning for; they must answer with zeros
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [15:0] CTL_EN   = 16'h1 << cpt_pkg::CTL_ENABLE_BIT;
    localparam logic [15:0] CTL_IRQ  = 16'h1 << cpt_pkg::CTL_IRQ_EN_BIT;
    localparam logic [15:0] CTL_CASC = 16'h1 << cpt_pkg::CTL_CASCADE_BIT;

    localparam logic [15:0] SEL_DIV1    = 16'(cpt_pkg::PSC_DIV1);
    localparam logic [15:0] SEL_DIV1024 = 16'(cpt_pkg::PSC_DIV1024);

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    cpt_pkg::req_t  req_data  = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    cpt_pkg::rsp_t  rsp_data;

    cascadable_prescaled_timers_unit #(
        .NUM_TIMERS (TIMERS),
        .MAX_CYCLES (CYCLE_CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Timer model: shadow copy of counters, reloads, control words and
    // prescale remainders, advanced once per accepted request.
    // ------------------------------------------------------------------------
    logic [15:0] shadow_count  [TIMERS];
    logic [15:0] shadow_reload [TIMERS];
    logic [15:0] shadow_ctrl   [TIMERS];
    logic [9:0]  shadow_rem    [TIMERS];
    logic [3:0]  raised_irq;

    cpt_pkg::rsp_t expected_responses[$];

    int  items_sent    = 0;
    int  errors        = 0;
    int  responses_ok  = 0;
    int  tick_count    = 0;
    int  irq_responses = 0;
    int  idle_cycles   = 0;
    bit  no_gaps       = 1'b0;
    int  hold_left     = 0;

    function automatic int prescale_span(input logic [1:0] sel);
        case (sel)
            cpt_pkg::PSC_DIV1:    return 1;
            cpt_pkg::PSC_DIV64:   return 64;
            cpt_pkg::PSC_DIV256:  return 256;
            default:              return 1024;
        endcase
    endfunction

    // Advance one timer by a single count; report whether it wrapped
    function automatic bit bump_timer(input int t);
        shadow_count[t] = shadow_count[t] + 16'd1;
        if (shadow_count[t] != 16'd0)
            return 1'b0;
        shadow_count[t] = shadow_reload[t];
        if (shadow_ctrl[t][cpt_pkg::CTL_IRQ_EN_BIT])
            raised_irq[t] = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [3:0] advance_timers(input int cycles);
        int span;
        int acc;
        int steps;
        int t;
        int k;
        int c;
        raised_irq = '0;
        if (cycles > CYCLE_CAP)
            cycles = CYCLE_CAP;
        for (t = 0; t < TIMERS; t++)
        begin
            // Cascaded timers count only through the chain, never on their own
            if (!shadow_ctrl[t][cpt_pkg::CTL_ENABLE_BIT]
                || shadow_ctrl[t][cpt_pkg::CTL_CASCADE_BIT])
                continue;
            span  = prescale_span(shadow_ctrl[t][1:0]);
            acc   = int'(shadow_rem[t]) + cycles;
            steps = acc / span;
            shadow_rem[t] = 10'(acc % span);
            for (k = 0; k < steps; k++)
            begin
                if (!bump_timer(t))
                    continue;
                // Ripple the wrap into following cascaded timers
                for (c = t + 1; c < TIMERS; c++)
                begin
                    if (!shadow_ctrl[c][cpt_pkg::CTL_ENABLE_BIT]
                        || !shadow_ctrl[c][cpt_pkg::CTL_CASCADE_BIT])
                        break;
                    if (!bump_timer(c))
                        break;
                end
            end
        end
        return raised_irq;
    endfunction

    function automatic cpt_pkg::rsp_t compute_response(input cpt_pkg::req_t item);
        cpt_pkg::rsp_t res;
        int            idx;
        res = '0;
        idx = int'(item.timer_index);
        case (item.operation)
            cpt_pkg::OP_TICK:
                res.timer_irq = advance_timers(int'(item.elapsed_cycles));
            cpt_pkg::OP_WR_RELOAD:
                shadow_reload[idx] = item.write_value;
            cpt_pkg::OP_WR_CONTROL:
            begin
                // Enable going high loads the counter; the remainder stays
                if (!shadow_ctrl[idx][cpt_pkg::CTL_ENABLE_BIT]
                    && item.write_value[cpt_pkg::CTL_ENABLE_BIT])
                    shadow_count[idx] = shadow_reload[idx];
                shadow_ctrl[idx] = item.write_value;
            end
            cpt_pkg::OP_RD_COUNT:
                res.read_data = shadow_count[idx];
            cpt_pkg::OP_RD_CONTROL:
                res.read_data = shadow_ctrl[idx];
            default:
                ;
        endcase
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cpt_pkg::req_t make_req(input logic [2:0] op, input int idx,
                                               input logic [15:0] val,
                                               input logic [7:0] cyc);
        cpt_pkg::req_t r;
        r.operation      = op;
        r.timer_index    = 2'(idx);
        r.write_value    = val;
        r.elapsed_cycles = cyc;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: hold valid through the wait for ready, then record the
    // prediction at the edge where the transfer happens.
    // ------------------------------------------------------------------------
    task automatic send_request(input cpt_pkg::req_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_responses.push_back(compute_response(item));
        items_sent++;
        if (item.operation == cpt_pkg::OP_TICK)
            tick_count++;
    endtask

    // ------------------------------------------------------------------------
    // Response side: stall ready at random, hold it high in quiet stretches.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // Compare every response transfer against the oldest prediction
    always @(posedge clk)
    begin
        cpt_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with nothing expected: read_data %h timer_irq %b",
                       rsp_data.read_data, rsp_data.timer_irq);
                errors++;
            end
            else
            begin
                exp_rsp = expected_responses.pop_front();
                if (rsp_data.read_data !== exp_rsp.read_data)
                begin
                    $error("read_data expected %h actual %h",
                           exp_rsp.read_data, rsp_data.read_data);
                    errors++;
                end
                if (rsp_data.timer_irq !== exp_rsp.timer_irq)
                begin
                    $error("timer_irq expected %b actual %b",
                           exp_rsp.timer_irq, rsp_data.timer_irq);
                    errors++;
                end
                if (exp_rsp.timer_irq != '0)
                    irq_responses++;
                responses_ok++;
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Reset values, full-width writes, and control bits that are only stored
    task automatic test_register_access();
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 0, 16'h0000, 8'h00));
        send_request(make_req(cpt_pkg::OP_RD_CONTROL, 3, 16'hFFFF, 8'hFF));
        send_request(make_req(cpt_pkg::OP_WR_RELOAD, 2, 16'hFFFF, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 2, 16'hFF7F, 8'h00));
        send_request(make_req(cpt_pkg::OP_RD_CONTROL, 2, 16'h0000, 8'h00));
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 2, 16'h0000, 8'h00));
    endtask

    // Spare codes change nothing and answer with zeros
    task automatic test_spare_codes();
        send_request(make_req(OP_SPARE_5, 1, 16'hFFFF, 8'hFF));
        send_request(make_req(OP_SPARE_6, 3, 16'hA5A5, 8'h5A));
        send_request(make_req(OP_SPARE_7, 0, 16'h0000, 8'h00));
    endtask

    // Divide-by-one timer with an interrupt, wrapping many times per item
    task automatic test_prescaler_tick();
        send_request(make_req(cpt_pkg::OP_WR_RELOAD, 0, 16'hFFF0, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 0, CTL_EN | CTL_IRQ | SEL_DIV1, 8'h00));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFF));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'h00));
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 0, 16'h0000, 8'h00));
    endtask

    // Wraps ripple through a chain of cascaded timers; timer 0 in cascade
    // mode has nothing to follow and stays still
    task automatic test_cascade_chain();
        no_gaps = 1'b1;
        send_request(make_req(cpt_pkg::OP_WR_RELOAD, 1, 16'hFFFF, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 1, CTL_EN | CTL_CASC | CTL_IRQ, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_RELOAD, 3, 16'hFFFE, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 3, CTL_EN | CTL_CASC | CTL_IRQ, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 2, CTL_EN | CTL_CASC | CTL_IRQ, 8'h00));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'h40));
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 3, 16'h0000, 8'h00));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 0, CTL_EN | CTL_CASC, 8'h00));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFF));
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 0, 16'h0000, 8'h00));
        no_gaps = 1'b0;
    endtask

    // Build a large remainder at divide-by-1024, then drop to divide-by-one
    // so that every period held in the remainder counts in one item
    task automatic test_prescaler_reduce();
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 0, CTL_EN | CTL_IRQ | SEL_DIV1024,
                              8'h00));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFF));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFF));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFF));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'hFE));
        send_request(make_req(cpt_pkg::OP_WR_CONTROL, 0, CTL_EN | CTL_IRQ | SEL_DIV1, 8'h00));
        send_request(make_req(cpt_pkg::OP_TICK, 0, 16'h0000, 8'h0A));
        send_request(make_req(cpt_pkg::OP_RD_COUNT, 0, 16'h0000, 8'h00));
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Program a few timers, then run ticks mixed with reads
    task automatic run_timer_scenario();
        int          t;
        int          n;
        logic [15:0] cw;
        logic [15:0] rv;
        for (t = 0; t < TIMERS; t++)
        begin
            if ($urandom_range(0, 1) == 0)
                continue;
            // Keep most reloads near the top so wraps come often
            rv = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                             : 16'hFFFF - 16'($urandom_range(0, 300));
            send_request(make_req(cpt_pkg::OP_WR_RELOAD, t, rv, 8'($urandom)));
        end
        for (t = 0; t < TIMERS; t++)
        begin
            if ($urandom_range(0, 2) == 0)
                continue;
            cw = 16'($urandom);
            cw[cpt_pkg::CTL_ENABLE_BIT]  = ($urandom_range(0, 4) != 0);
            cw[cpt_pkg::CTL_CASCADE_BIT] = (t != 0) ? 1'($urandom_range(0, 1))
                                                    : 1'($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1) == 0)
                cw[1:0] = cpt_pkg::PSC_DIV1;
            // Drop enable first at times so the next write loads the counter
            if ($urandom_range(0, 1) == 0)
                send_request(make_req(cpt_pkg::OP_WR_CONTROL, t, cw & ~CTL_EN,
                                      8'($urandom)));
            send_request(make_req(cpt_pkg::OP_WR_CONTROL, t, cw, 8'($urandom)));
        end
        n = $urandom_range(2, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: send_request(make_req(cpt_pkg::OP_RD_COUNT, $urandom_range(0, 3),
                                         16'($urandom), 8'($urandom)));
                1: send_request(make_req(cpt_pkg::OP_RD_CONTROL, $urandom_range(0, 3),
                                         16'($urandom), 8'($urandom)));
                default: send_request(make_req(cpt_pkg::OP_TICK, $urandom_range(0, 3),
                                               16'($urandom), 8'($urandom)));
            endcase
        end
    endtask

    task automatic test_random_traffic(input int budget);
        int stop_at;
        int k;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                // Fully random requests, spare codes included
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_request(make_req(3'($urandom_range(0, 7)), $urandom_range(0, 3),
                                          16'($urandom), 8'($urandom)));
            end
            else
                run_timer_scenario();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        int t;
        for (t = 0; t < TIMERS; t++)
        begin
            shadow_count[t]  = '0;
            shadow_reload[t] = '0;
            shadow_ctrl[t]   = '0;
            shadow_rem[t]    = '0;
        end

        // Hold reset low, then release it at an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_spare_codes();
        test_prescaler_tick();
        test_cascade_chain();
        test_prescaler_reduce();
        test_random_traffic(800);
        req_valid <= 1'b0;

        // Drain outstanding responses; the watchdog bounds this wait
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d requests, %0d of them tick transfers", items_sent, tick_count);
        $display("%0d responses checked, %0d carried interrupt bits",
                 responses_ok, irq_responses);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
